FILE: src/bpc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the pressure/temperature compensation pipeline
// no dependencies; used by bpc_front, bpc_div, bpc_back and the top level
package bpc_pkg;

    // raw reading width and the codes of a skipped, stuck or zero conversion
    localparam int ADC_W = 20;
    localparam logic [ADC_W-1:0] ADC_SKIP  = 20'h80000;
    localparam logic [ADC_W-1:0] ADC_STUCK = 20'hFFFFF;
    localparam logic [ADC_W-1:0] ADC_ZERO  = 20'h00000;

    // calibration register layout
    localparam int CAL_W  = 48;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    // divider geometry: divisor magnitude, quotient bits, dividend bits fed serially
    localparam int DM_W  = 42;
    localparam int QUO_W = 37;
    localparam int LO_W  = 21;

    // output widths
    localparam int TEMP_W  = 16;
    localparam int PRESS_W = 25;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SKIP  = 2'd1,
        ST_ZERO  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_TEMP_CAL    = 2'd0,
        REG_PRESS_CAL_A = 2'd1,
        REG_PRESS_CAL_B = 2'd2,
        REG_PRESS_CAL_C = 2'd3
    } t_reg_idx;

    // unpacked calibration words
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_cal;

    // per-item information that rides along the whole pipeline
    typedef struct packed {
        t_status            status;
        logic [TEMP_W-1:0]  temp;
    } t_side;

    // partial state of the long division
    typedef struct packed {
        logic [DM_W-1:0]  r;
        logic [QUO_W-1:0] q;
        logic [LO_W-1:0]  lo;
        logic [DM_W-1:0]  dm;
        logic             sat;
        logic             neg;
    } t_div;

endpackage

FILE: src/bpc_front.sv
`timescale 1ns / 1ps
// front pipeline: input screening, temperature polynomial, pressure divisor and numerator
// depends on bpc_pkg; feeds bpc_div
module bpc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [19:0]       i_adc_pressure,
    input  logic [19:0]       i_adc_temp,
    input  bpc_pkg::t_cal     i_cal,
    output logic              o_valid,
    input  logic              i_ready,
    output bpc_pkg::t_div     o_div,
    output bpc_pkg::t_side    o_side
);
    import bpc_pkg::*;

    localparam int NSTG = 10;
    localparam logic signed [59:0] A_OFS = 60'sd2199023255552000;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   w_en;

    // stage advance chain: a stage moves when empty or when the next one moves
    assign w_en[NSTG] = i_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];

    // signed calibration words
    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p5, w_p6;
    assign w_t2 = $signed(i_cal.t2);
    assign w_t3 = $signed(i_cal.t3);
    assign w_p2 = $signed(i_cal.p2);
    assign w_p3 = $signed(i_cal.p3);
    assign w_p5 = $signed(i_cal.p5);
    assign w_p6 = $signed(i_cal.p6);

    // stage 1: screening and temperature offset
    logic signed [21:0] n1_d, r1_d;
    t_status            n1_st, r1_st;
    logic [19:0]        r1_ap;
    always_comb begin
        n1_d = $signed({2'b00, i_adc_temp}) - $signed({2'b00, i_cal.t1, 4'b0000});
        if (i_adc_pressure == ADC_SKIP || i_adc_temp == ADC_SKIP ||
            i_adc_pressure == ADC_ZERO || i_adc_pressure == ADC_STUCK) begin
            n1_st = ST_SKIP;
        end else begin
            n1_st = ST_OK;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_d  <= n1_d;
            r1_st <= n1_st;
            r1_ap <= i_adc_pressure;
        end
    end

    // stage 2: linear and square terms
    logic signed [37:0] r2_m1;
    logic signed [43:0] r2_m2;
    t_status            r2_st;
    logic [19:0]        r2_ap;
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_m1 <= r1_d * w_t2;
            r2_m2 <= r1_d * r1_d;
            r2_st <= r1_st;
            r2_ap <= r1_ap;
        end
    end

    // stage 3: fine temperature sum
    logic signed [58:0] r3_f;
    t_status            r3_st;
    logic [19:0]        r3_ap;
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_f  <= $signed({r2_m1, 20'b0}) + r2_m2 * w_t3;
            r3_st <= r2_st;
            r3_ap <= r2_ap;
        end
    end

    // stage 4: rounded, saturated temperature and the pressure offset term
    logic signed [61:0] w4_f, w4_t5, w4_tq;
    logic signed [59:0] w4_fa, w4_as;
    logic [15:0]        n4_temp;
    logic signed [31:0] r4_a;
    t_side              r4_side;
    logic [19:0]        r4_ap;
    always_comb begin
        w4_f  = r3_f;
        w4_t5 = (w4_f <<< 2) + w4_f + (62'sd1 <<< 41);
        w4_tq = w4_t5 >>> 42;
        if (w4_tq > 62'sd32767) begin
            n4_temp = 16'h7FFF;
        end else if (w4_tq < -62'sd32768) begin
            n4_temp = 16'h8000;
        end else begin
            n4_temp = w4_tq[15:0];
        end
        w4_fa = r3_f - A_OFS;
        w4_as = w4_fa >>> 27;
    end
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_a           <= w4_as[31:0];
            r4_side.status <= r3_st;
            r4_side.temp   <= n4_temp;
            r4_ap          <= r3_ap;
        end
    end

    // stage 5: square of the offset and the first-order products
    logic signed [63:0] w5_aa;
    logic [44:0]        r5_h;
    logic signed [47:0] r5_pa5, r5_pa2;
    t_side              r5_side;
    logic [19:0]        r5_ap;
    assign w5_aa = r4_a * r4_a;
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_h    <= w5_aa[60:16];
            r5_pa5  <= r4_a * w_p5;
            r5_pa2  <= r4_a * w_p2;
            r5_side <= r4_side;
            r5_ap   <= r4_ap;
        end
    end

    // stage 6: second-order products
    logic signed [45:0] w6_h;
    logic signed [61:0] r6_hp6, r6_p3h;
    logic signed [47:0] r6_pa5, r6_pa2;
    t_side              r6_side;
    logic [19:0]        r6_ap;
    assign w6_h = $signed({1'b0, r5_h});
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_hp6  <= w6_h * w_p6;
            r6_p3h  <= w6_h * w_p3;
            r6_pa5  <= r5_pa5;
            r6_pa2  <= r5_pa2;
            r6_side <= r5_side;
            r6_ap   <= r5_ap;
        end
    end

    // stage 7: offset polynomial and divisor gain
    logic signed [49:0] r7_w16;
    logic signed [40:0] r7_g32;
    t_side              r7_side;
    logic [19:0]        r7_ap;
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_w16  <= 50'((r6_hp6 >>> 13) + (r6_pa5 >>> 5) + $signed({i_cal.p4, 20'b0}));
            r7_g32  <= 41'((41'sd1 <<< 32) + (r6_p3h >>> 21) + (r6_pa2 >>> 10));
            r7_side <= r6_side;
            r7_ap   <= r6_ap;
        end
    end

    // stage 8: divisor and numerator
    logic signed [57:0] w8_pg;
    logic [20:0]        w8_pd;
    logic signed [41:0] r8_d16;
    logic signed [50:0] r8_n16;
    t_side              r8_side;
    assign w8_pg = $signed({1'b0, i_cal.p1}) * r7_g32;
    assign w8_pd = 21'h100000 - {1'b0, r7_ap};
    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r8_d16  <= 42'(w8_pg >>> 16);
            r8_n16  <= $signed({14'b0, w8_pd, 16'b0}) - r7_w16;
            r8_side <= r7_side;
        end
    end

    // stage 9: numerator scale and zero-divisor check
    logic signed [62:0] r9_num;
    logic signed [41:0] r9_d16;
    t_side              n9_side, r9_side;
    always_comb begin
        n9_side = r8_side;
        if (r8_side.status == ST_OK && r8_d16 == '0) begin
            n9_side.status = ST_ZERO;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r9_num  <= r8_n16 * 63'sd6250;
            r9_d16  <= r8_d16;
            r9_side <= n9_side;
        end
    end

    // stage 10: magnitudes, overflow clamp test and first partial remainder
    logic signed [62:0] w10_nn;
    logic signed [41:0] w10_nd;
    logic [61:0]        w10_nm;
    logic [41:0]        w10_dm;
    t_div               n10_div, r10_div;
    t_side              r10_side;
    always_comb begin
        w10_nn      = -r9_num;
        w10_nd      = -r9_d16;
        w10_nm      = r9_num[62] ? w10_nn[61:0] : r9_num[61:0];
        w10_dm      = r9_d16[41] ? w10_nd : r9_d16;
        n10_div.r   = {1'b0, w10_nm[61:LO_W]};
        n10_div.q   = '0;
        n10_div.lo  = w10_nm[LO_W-1:0];
        n10_div.dm  = w10_dm;
        n10_div.sat = {1'b0, w10_nm} >= {w10_dm, 21'b0};
        n10_div.neg = r9_num[62] ^ r9_d16[41];
    end
    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r10_div  <= n10_div;
            r10_side <= r9_side;
        end
    end

    assign o_div  = r10_div;
    assign o_side = r10_side;

endmodule

FILE: src/bpc_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// depends on bpc_pkg; sits between bpc_front and bpc_back
module bpc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bpc_pkg::t_div     i_div,
    input  bpc_pkg::t_side    i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output bpc_pkg::t_div     o_div,
    output bpc_pkg::t_side    o_side
);
    import bpc_pkg::*;

    // one compare-subtract step, bringing in the next dividend bit
    function automatic t_div f_step(input t_div x);
        t_div          y;
        logic [DM_W:0] rs;
        logic [DM_W:0] df;
        y  = x;
        rs = {x.r, x.lo[LO_W-1]};
        df = rs - {1'b0, x.dm};
        y.lo = {x.lo[LO_W-2:0], 1'b0};
        if (rs >= {1'b0, x.dm}) begin
            y.r = df[DM_W-1:0];
            y.q = {x.q[QUO_W-2:0], 1'b1};
        end else begin
            y.r = rs[DM_W-1:0];
            y.q = {x.q[QUO_W-2:0], 1'b0};
        end
        return y;
    endfunction

    logic  r_v    [QUO_W];
    t_div  r_div  [QUO_W];
    t_side r_side [QUO_W];
    logic  w_vin  [QUO_W];
    t_div  w_din  [QUO_W];
    t_side w_sin  [QUO_W];
    logic  [QUO_W:0] w_en;

    assign w_en[QUO_W] = i_ready;
    assign w_vin[0]    = i_valid;
    assign w_din[0]    = i_div;
    assign w_sin[0]    = i_side;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        if (k > 0) begin : g_link
            assign w_vin[k] = r_v[k-1];
            assign w_din[k] = r_div[k-1];
            assign w_sin[k] = r_side[k-1];
        end

        assign w_en[k] = !r_v[k] || w_en[k+1];

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_vin[k];
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_div[k]  <= f_step(w_din[k]);
                r_side[k] <= w_sin[k];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[QUO_W-1];
    assign o_div   = r_div[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

FILE: src/bpc_back.sv
`timescale 1ns / 1ps
// back pipeline: signed quotient, second-order pressure correction, range check
// depends on bpc_pkg; its last stage is the output register
module bpc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bpc_pkg::t_div     i_div,
    input  bpc_pkg::t_side    i_side,
    input  bpc_pkg::t_cal     i_cal,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [15:0]       o_temperature,
    output logic [24:0]       o_pressure
);
    import bpc_pkg::*;

    localparam int NSTG = 4;
    localparam logic signed [44:0] F_LO = 45'sd1966080000;
    localparam logic signed [44:0] F_HI = 45'sd7208960000;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   w_en;

    assign w_en[NSTG] = i_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];

    // stage 1: clamp and sign the quotient
    logic [37:0]        w1_mag;
    logic signed [38:0] w1_pm, n1_p16, w1_s;
    logic signed [38:0] r1_p16;
    logic signed [30:0] r1_s;
    t_side              r1_side;
    always_comb begin
        w1_mag = i_div.sat ? (38'd1 << QUO_W) : {1'b0, i_div.q};
        w1_pm  = $signed({1'b0, w1_mag});
        n1_p16 = i_div.neg ? -w1_pm : w1_pm;
        w1_s   = n1_p16 >>> 8;
    end
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_p16  <= n1_p16;
            r1_s    <= w1_s[30:0];
            r1_side <= i_side;
        end
    end

    // stage 2: square of the pressure and the linear correction
    logic signed [61:0] w2_ss;
    logic [44:0]        r2_q;
    logic signed [54:0] r2_pp8;
    logic signed [38:0] r2_p16;
    t_side              r2_side;
    assign w2_ss = r1_s * r1_s;
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_q    <= w2_ss[60:16];
            r2_pp8  <= r1_p16 * $signed(i_cal.p8);
            r2_p16  <= r1_p16;
            r2_side <= r1_side;
        end
    end

    // stage 3: quadratic correction
    logic signed [61:0] r3_qp9;
    logic signed [54:0] r3_pp8;
    logic signed [38:0] r3_p16;
    t_side              r3_side;
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_qp9  <= $signed({1'b0, r2_q}) * $signed(i_cal.p9);
            r3_pp8  <= r2_pp8;
            r3_p16  <= r2_p16;
            r3_side <= r2_side;
        end
    end

    // stage 4: final sum, range check and output register
    logic signed [44:0] w4_f16, w4_pr;
    t_status            n4_st;
    logic [1:0]         r4_status;
    logic [15:0]        r4_temp;
    logic [24:0]        r4_press;
    always_comb begin
        w4_f16 = 45'(r3_p16 + (r3_qp9 >>> 19) + (r3_pp8 >>> 19)
                      + $signed({i_cal.p7, 12'b0}));
        w4_pr  = (w4_f16 + 45'sd128) >>> 8;
        n4_st  = r3_side.status;
        if (n4_st == ST_OK && (w4_f16 < F_LO || w4_f16 > F_HI)) begin
            n4_st = ST_RANGE;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_status <= n4_st;
            r4_temp   <= (n4_st == ST_SKIP) ? '0 : r3_side.temp;
            r4_press  <= (n4_st == ST_OK) ? w4_pr[24:0] : '0;
        end
    end

    assign o_status      = r4_status;
    assign o_temperature = r4_temp;
    assign o_pressure    = r4_press;

endmodule

FILE: src/baro_temp_pressure_compensation.sv
`timescale 1ns / 1ps
// top level: calibration registers on the APB port and the compensation pipeline
// depends on bpc_pkg, bpc_front, bpc_div and bpc_back

// Takes one raw pressure/temperature pair per cycle and returns status, temperature
// in 0.01 degC and pressure in 1/256 Pa. Every item passes through 10 front stages
// for the temperature and divisor polynomials, 37 stages of the one-bit-per-stage
// divider that forms the pressure quotient, and 4 back stages whose last is the output
// register. A new item is taken every cycle unless a stalled output has filled every stage;
// a stalled output holds only the stages behind it that are full, so gaps fill up. The four
// 48-bit calibration registers sit at byte addresses 0, 8, 16 and 24 and are to be
// written while the pipeline is empty.
module baro_temp_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [19:0] i_adc_pressure,
    input  logic [19:0] i_adc_temp,
    // result output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic signed [15:0] o_temperature,
    output logic [bpc_pkg::PRESS_W-1:0] o_pressure,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0] paddr,
    input  logic [bpc_pkg::DATA_W-1:0] pwdata,
    output logic [bpc_pkg::DATA_W-1:0] prdata,
    output logic        pready
);
    import bpc_pkg::*;

    logic [CAL_W-1:0] r_temp_cal, r_press_cal_a, r_press_cal_b, r_press_cal_c;
    t_reg_idx         w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:3]);
    assign w_wr   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal    <= '0;
            r_press_cal_a <= '0;
            r_press_cal_b <= '0;
            r_press_cal_c <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_TEMP_CAL:    r_temp_cal    <= pwdata[CAL_W-1:0];
                REG_PRESS_CAL_A: r_press_cal_a <= pwdata[CAL_W-1:0];
                REG_PRESS_CAL_B: r_press_cal_b <= pwdata[CAL_W-1:0];
                REG_PRESS_CAL_C: r_press_cal_c <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_idx)
            REG_TEMP_CAL:    prdata = {16'b0, r_temp_cal};
            REG_PRESS_CAL_A: prdata = {16'b0, r_press_cal_a};
            REG_PRESS_CAL_B: prdata = {16'b0, r_press_cal_b};
            REG_PRESS_CAL_C: prdata = {16'b0, r_press_cal_c};
            default:         prdata = '0;
        endcase
    end

    // calibration word split
    t_cal w_cal;
    assign w_cal.t1 = r_temp_cal[15:0];
    assign w_cal.t2 = r_temp_cal[31:16];
    assign w_cal.t3 = r_temp_cal[47:32];
    assign w_cal.p1 = r_press_cal_a[15:0];
    assign w_cal.p2 = r_press_cal_a[31:16];
    assign w_cal.p3 = r_press_cal_a[47:32];
    assign w_cal.p4 = r_press_cal_b[15:0];
    assign w_cal.p5 = r_press_cal_b[31:16];
    assign w_cal.p6 = r_press_cal_b[47:32];
    assign w_cal.p7 = r_press_cal_c[15:0];
    assign w_cal.p8 = r_press_cal_c[31:16];
    assign w_cal.p9 = r_press_cal_c[47:32];

    // pipeline sections
    logic  w_fd_valid, w_fd_ready, w_db_valid, w_db_ready;
    t_div  w_fd_div, w_db_div;
    t_side w_fd_side, w_db_side;
    logic [15:0] w_temp;

    bpc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_adc_pressure (i_adc_pressure),
        .i_adc_temp     (i_adc_temp),
        .i_cal          (w_cal),
        .o_valid        (w_fd_valid),
        .i_ready        (w_fd_ready),
        .o_div          (w_fd_div),
        .o_side         (w_fd_side)
    );

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fd_valid),
        .o_ready (w_fd_ready),
        .i_div   (w_fd_div),
        .i_side  (w_fd_side),
        .o_valid (w_db_valid),
        .i_ready (w_db_ready),
        .o_div   (w_db_div),
        .o_side  (w_db_side)
    );

    bpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_db_valid),
        .o_ready       (w_db_ready),
        .i_div         (w_db_div),
        .i_side        (w_db_side),
        .i_cal         (w_cal),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_temperature (w_temp),
        .o_pressure    (o_pressure)
    );

    assign o_temperature = $signed(w_temp);

    // a skipped reading carries no temperature and no pressure
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SKIP |-> o_temperature == '0 && o_pressure == '0)
        else $error("skipped reading with nonzero result");

    // a good result lies inside the accepted pressure window
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_pressure >= 25'd7680000 && o_pressure <= 25'd28160000)
        else $error("good pressure outside window");

    // divisor and range faults clear the pressure
    a_fault_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ZERO || o_status == ST_RANGE) |-> o_pressure == '0)
        else $error("faulted result with nonzero pressure");

    // nothing leaves the pipeline right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

FILE: bench/baro_temp_pressure_compensation_test.sv
`timescale 1ns / 1ps
// self-checking bench for baro_temp_pressure_compensation: directed table, then random phases
// depends on bpc_pkg and the block; every transfer is checked against an in-bench predictor or a table entry
module baro_temp_pressure_compensation_test;
    import bpc_pkg::*;

    localparam int ITEMS_PER_PHASE = 108;
    localparam int PHASES          = 12;
    localparam int DRAIN_CYCLES    = 60;
    localparam int STALL_LIMIT     = 20000;
    localparam int LONG_HOLD       = 300;

    typedef struct {
        t_status            st;
        logic signed [15:0] temp;
        logic [24:0]        press;
    } t_comp;

    typedef struct {
        logic [19:0]        p;
        logic [19:0]        t;
        bit                 typed;
        t_status            st;
        logic signed [15:0] temp;
        logic [24:0]        press;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [19:0] i_adc_pressure;
    logic [19:0] i_adc_temp;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic signed [15:0] o_temperature;
    logic [24:0] o_pressure;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // calibration copy held by the predictor
    logic [47:0] cal_regs [4];

    t_comp expected_results[$];
    int    errors;
    int    idle_cycles;
    bit    steady;
    bit    hold_req;
    int    hold_left;
    int    ready_gap;

    baro_temp_pressure_compensation DUT (.*);

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic longint zx16(logic [15:0] v);
        return {48'd0, v};
    endfunction

    // fixed-point compensation of one reading pair
    function automatic t_comp compensate(logic [19:0] ap_in, logic [19:0] at_in);
        t_comp  r;
        longint ap, at, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint d, f, temp, a, h, w16, g32, d16, n16, num, p16, s, q, f16;
        longint unsigned nm, dm, qq, rr, mag;
        bit neg;
        r.st = ST_OK;
        r.temp = '0;
        r.press = '0;
        if (ap_in == ADC_SKIP || at_in == ADC_SKIP || ap_in == ADC_ZERO || ap_in == ADC_STUCK) begin
            r.st = ST_SKIP;
            return r;
        end
        ap = {44'd0, ap_in};
        at = {44'd0, at_in};
        t1 = zx16(cal_regs[REG_TEMP_CAL][15:0]);
        t2 = sx16(cal_regs[REG_TEMP_CAL][31:16]);
        t3 = sx16(cal_regs[REG_TEMP_CAL][47:32]);
        p1 = zx16(cal_regs[REG_PRESS_CAL_A][15:0]);
        p2 = sx16(cal_regs[REG_PRESS_CAL_A][31:16]);
        p3 = sx16(cal_regs[REG_PRESS_CAL_A][47:32]);
        p4 = sx16(cal_regs[REG_PRESS_CAL_B][15:0]);
        p5 = sx16(cal_regs[REG_PRESS_CAL_B][31:16]);
        p6 = sx16(cal_regs[REG_PRESS_CAL_B][47:32]);
        p7 = sx16(cal_regs[REG_PRESS_CAL_C][15:0]);
        p8 = sx16(cal_regs[REG_PRESS_CAL_C][31:16]);
        p9 = sx16(cal_regs[REG_PRESS_CAL_C][47:32]);

        // temperature polynomial, saturated
        d = at - 16 * t1;
        f = d * t2 * 1048576 + d * d * t3;
        temp = (5 * f + (longint'(1) <<< 41)) >>> 42;
        if (temp > 32767) temp = 32767;
        if (temp < -32768) temp = -32768;
        r.temp = temp[15:0];

        // divisor and offset terms
        a = (f - 64000 * (longint'(1) <<< 35)) >>> 27;
        h = (a * a) >>> 16;
        w16 = ((h * p6) >>> 13) + ((a * p5) >>> 5) + p4 * 1048576;
        g32 = (longint'(1) <<< 32) + ((p3 * h) >>> 21) + ((p2 * a) >>> 10);
        d16 = (p1 * g32) >>> 16;
        if (d16 == 0) begin
            r.st = ST_ZERO;
            return r;
        end

        // signed quotient on magnitudes, clamped at 2^21 Pa
        n16 = (1048576 - ap) * 65536 - w16;
        num = n16 * 6250;
        neg = (num < 0) != (d16 < 0);
        nm = (num < 0) ? -num : num;
        dm = (d16 < 0) ? -d16 : d16;
        qq = nm / dm;
        rr = nm % dm;
        if (qq >= (64'd1 << 21))
            mag = 64'd1 << 37;
        else
            mag = (qq << 16) + ((rr << 16) / dm);
        p16 = neg ? -longint'(mag) : longint'(mag);

        // second-order correction and range check
        s = p16 >>> 8;
        q = (s * s) >>> 16;
        f16 = p16 + ((q * p9) >>> 19) + ((p16 * p8) >>> 19) + p7 * 4096;
        if (f16 < longint'(30000) * 65536 || f16 > longint'(110000) * 65536) begin
            r.st = ST_RANGE;
            return r;
        end
        f16 = (f16 + 128) >>> 8;
        r.press = f16[24:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // random gap length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: ready pattern with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= LONG_HOLD;
            hold_req  <= 1'b0;
            i_ready   <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
        end else if (hold_left == 1) begin
            hold_left <= 0;
            i_ready   <= 1'b1;
        end else if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
            i_ready   <= (ready_gap == 1);
        end else begin
            ready_gap <= gap_len();
            i_ready   <= (gap_len() == 0);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_comp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result transfer at %0t", $realtime);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_status != want.st) report_mismatch("status", o_status, want.st);
                if (o_temperature != want.temp)
                    report_mismatch("temperature", o_temperature, want.temp);
                if (o_pressure != want.press) report_mismatch("pressure", o_pressure, want.press);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("baro_temp_pressure_compensation test failed");
            $finish;
        end
    end

    // one register write over the configuration port
    task automatic write_cal(t_reg_idx idx, logic [47:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(8 * idx);
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cal_regs[idx] = value;
    endtask

    task automatic write_all(logic [47:0] tc, logic [47:0] pa, logic [47:0] pb, logic [47:0] pc);
        write_cal(REG_TEMP_CAL, tc);
        write_cal(REG_PRESS_CAL_A, pa);
        write_cal(REG_PRESS_CAL_B, pb);
        write_cal(REG_PRESS_CAL_C, pc);
    endtask

    // offer one reading pair; valid stays high across back-to-back transfers
    task automatic send_pair(logic [19:0] p, logic [19:0] t, bit typed, t_comp want);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_adc_pressure <= p;
        i_adc_temp     <= t;
        do @(posedge i_clk); while (!o_ready);
        expected_results.push_back(typed ? want : compensate(p, t));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // typical calibration, optionally jittered per word
    function automatic logic [47:0] pack3(int a, int b, int c, int jit);
        int ja, jb, jc;
        ja = a + $signed($urandom_range(0, 2 * jit)) - jit;
        jb = b + $signed($urandom_range(0, 2 * jit)) - jit;
        jc = c + $signed($urandom_range(0, 2 * jit)) - jit;
        return {16'(jc), 16'(jb), 16'(ja)};
    endfunction

    task automatic write_typical(int jit);
        write_all(pack3(27504, 26435, -1000, jit), pack3(36477, -10685, 3024, jit),
                  pack3(2855, 140, -7, jit), pack3(15500, -14600, 6000, jit));
    endtask

    initial begin
        t_row  rows[$];
        t_comp want;
        int    cal_mode, r;
        logic [19:0] p, t;

        errors = 0;
        idle_cycles = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        ready_gap = 0;
        foreach (cal_regs[k]) cal_regs[k] = '0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_ready        <= 1'b0;
        i_adc_pressure <= '0;
        i_adc_temp     <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset calibration gives a zero divisor, skip codes give zeros
        rows = '{
            '{20'd500000, 20'd500000, 1, ST_ZERO, 16'sd0, 25'd0},
            '{ADC_ZERO,   20'd500000, 1, ST_SKIP, 16'sd0, 25'd0},
            '{ADC_SKIP,   20'd500000, 1, ST_SKIP, 16'sd0, 25'd0},
            '{ADC_STUCK,  20'd500000, 1, ST_SKIP, 16'sd0, 25'd0},
            '{20'd500000, ADC_SKIP,   1, ST_SKIP, 16'sd0, 25'd0},
            '{20'd1,      20'd0,      1, ST_ZERO, 16'sd0, 25'd0},
            '{20'hFFFFE,  20'hFFFFF,  1, ST_ZERO, 16'sd0, 25'd0}
        };
        want = '{ST_OK, 16'sd0, 25'd0};
        foreach (rows[k]) begin
            want = '{rows[k].st, rows[k].temp, rows[k].press};
            send_pair(rows[k].p, rows[k].t, 1'b1, want);
        end
        drain();

        // directed: typical calibration, extremes and mid-scale readings
        write_typical(0);
        rows = '{
            '{20'd415148, 20'd519888, 0, ST_OK, 16'sd0, 25'd0},
            '{20'd1,      20'd0,      0, ST_OK, 16'sd0, 25'd0},
            '{20'hFFFFE,  20'hFFFFF,  0, ST_OK, 16'sd0, 25'd0},
            '{20'h7FFFF,  20'h7FFFF,  0, ST_OK, 16'sd0, 25'd0},
            '{20'h80001,  20'h80001,  0, ST_OK, 16'sd0, 25'd0},
            '{20'h55555,  20'hAAAAA,  0, ST_OK, 16'sd0, 25'd0},
            '{20'hAAAAA,  20'h55555,  0, ST_OK, 16'sd0, 25'd0},
            '{20'd300000, 20'd400000, 0, ST_OK, 16'sd0, 25'd0},
            '{20'd600000, 20'd600000, 0, ST_OK, 16'sd0, 25'd0},
            '{ADC_ZERO,   ADC_ZERO,   1, ST_SKIP, 16'sd0, 25'd0}
        };
        foreach (rows[k]) begin
            want = '{rows[k].st, rows[k].temp, rows[k].press};
            send_pair(rows[k].p, rows[k].t, rows[k].typed, want);
        end
        drain();

        // random phases, each under its own calibration
        for (int ph = 0; ph < PHASES; ph++) begin
            cal_mode = (ph == 1) ? 2 : (ph == 2) ? 3 : $urandom_range(0, 4);
            case (cal_mode)
                0, 4: write_typical(cal_mode == 0 ? 40 : 2000);
                1: write_all(48'($urandom) << 16 | 48'($urandom), {16'($urandom), 32'($urandom)},
                             {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
                2: write_all('1, '1, '1, '1);
                default: write_all('0, '0, '0, '0);
            endcase
            steady = (ph == 5);
            if (ph == 4) hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    case ($urandom_range(0, 3))
                        0: begin p = ADC_ZERO; t = 20'($urandom); end
                        1: begin p = ADC_SKIP; t = 20'($urandom); end
                        2: begin p = ADC_STUCK; t = 20'($urandom); end
                        default: begin p = 20'($urandom); t = ADC_SKIP; end
                    endcase
                end else if (r < 70) begin
                    p = 20'($urandom_range(200000, 700000));
                    t = 20'($urandom_range(350000, 650000));
                end else begin
                    p = 20'($urandom);
                    t = 20'($urandom);
                end
                send_pair(p, t, 1'b0, want);
            end
            steady = 1'b0;
            drain();
        end

        if (errors == 0)
            $display("baro_temp_pressure_compensation test passed");
        else
            $display("baro_temp_pressure_compensation test failed");
        $finish;
    end
endmodule
